// File: src/bsdd_pkg.sv
// Shared types, constants and helper functions for the binned second-difference decoder.
// No dependencies; imported by bsdd_core and binned_second_difference_decoder.
package bsdd_pkg;

    // Bin geometry.
    localparam int NUM_BINS = 32;
    localparam int BIN_SIZE = 16;
    localparam int FAC_DEPTH = 32;
    localparam int FAC_IDX_W = 5;
    localparam int FAC_WORD_W = 2;
    localparam int BIN_W = $clog2(NUM_BINS + 1);
    localparam int VIB_W = $clog2(BIN_SIZE + 1);

    // Field and state widths.
    localparam int BYTE_W = 8;
    localparam int VAL_W = 40;
    localparam int CNT_W = 15;
    localparam int HDR_W = 24;
    localparam int ACC_W = 28;
    localparam int NT_W = 3;
    localparam int FAC_W = 3;
    localparam int OFF_W = 5;

    // Byte offsets of the segment header.
    localparam logic [OFF_W-1:0] OFF_COUNT_HI  = 5'd7;
    localparam logic [OFF_W-1:0] OFF_COUNT_LO  = 5'd8;
    localparam logic [OFF_W-1:0] OFF_VALUE_HI  = 5'd9;
    localparam logic [OFF_W-1:0] OFF_VALUE_END = 5'd11;
    localparam logic [OFF_W-1:0] OFF_DIFF_HI   = 5'd12;
    localparam logic [OFF_W-1:0] OFF_DIFF_END  = 5'd14;
    localparam logic [OFF_W-1:0] OFF_FAC0_HI   = 5'd15;
    localparam logic [OFF_W-1:0] OFF_FAC0_END  = 5'd17;
    localparam logic [OFF_W-1:0] OFF_FAC1_HI   = 5'd18;
    localparam logic [OFF_W-1:0] OFF_FAC1_END  = 5'd20;
    localparam logic [OFF_W-1:0] OFF_FAC2_HI   = 5'd21;
    localparam logic [OFF_W-1:0] OFF_FAC2_END  = 5'd23;
    localparam logic [OFF_W-1:0] OFF_FAC3_HI   = 5'd24;
    localparam logic [OFF_W-1:0] OFF_FAC3_END  = 5'd26;
    localparam logic [OFF_W-1:0] DATA_START    = 5'd27;

    // Result of one processing step of the core.
    typedef struct packed {
        logic             emit;
        logic             more;
        logic             last;
        logic             trunc;
        logic [VAL_W-1:0] value;
    } core_out_t;

    // First bin at or after start, below NUM_BINS, with a nonzero factor; NUM_BINS if none.
    function automatic logic [BIN_W-1:0] next_bin(input logic [FAC_DEPTH-1:0] nz,
                                                  input logic [BIN_W-1:0] start);
        logic [BIN_W-1:0] res;
        res = BIN_W'(NUM_BINS);
        for (int b = FAC_DEPTH - 1; b >= 0; b--) begin
            if (nz[b] && (b >= int'(start)) && (b < NUM_BINS)) begin
                res = BIN_W'(b);
            end
        end
        return res;
    endfunction

    // Sign-extend a value of f nibbles held in the low bits of the accumulator.
    function automatic logic [VAL_W-1:0] sext_nibbles(input logic [ACC_W-1:0] acc,
                                                      input logic [FAC_W-1:0] f);
        logic [VAL_W-1:0] res;
        case (f)
            3'd1:    res = {{36{acc[3]}}, acc[3:0]};
            3'd2:    res = {{32{acc[7]}}, acc[7:0]};
            3'd3:    res = {{28{acc[11]}}, acc[11:0]};
            3'd4:    res = {{24{acc[15]}}, acc[15:0]};
            3'd5:    res = {{20{acc[19]}}, acc[19:0]};
            3'd6:    res = {{16{acc[23]}}, acc[23:0]};
            3'd7:    res = {{12{acc[27]}}, acc[27:0]};
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

// File: src/bsdd_core.sv
// Decoder state and per-step logic: header parsing, packing factors and nibble integration.
// Depends on bsdd_pkg; instantiated by binned_second_difference_decoder.
module bsdd_core
    import bsdd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [BYTE_W-1:0] byte_in,
    input  logic              first_in,
    input  logic              half_in,
    output core_out_t         res
);

    logic [OFF_W-1:0]   offset_reg, offset_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [HDR_W-1:0]   hdr_reg, hdr_next;
    logic [VAL_W-1:0]   val_reg, val_next;
    logic [VAL_W-1:0]   diff_reg, diff_next;
    logic [BIN_W-1:0]   bin_reg, bin_next;
    logic [VIB_W-1:0]   vib_reg, vib_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [NT_W-1:0]    nt_reg, nt_next;
    logic               done_reg, done_next;
    logic [FAC_W-1:0]   fac_reg [FAC_DEPTH];

    logic                  fac_we;
    logic [FAC_WORD_W-1:0] fac_word;
    logic [HDR_W-1:0]      fac_last_word;
    logic [FAC_DEPTH-1:0]  nz_cur;
    logic [FAC_DEPTH-1:0]  nz_new;
    logic [CNT_W-1:0]      cnt_raw;
    logic [FAC_W-1:0]      fac_sel;
    logic [3:0]            nib;
    logic [ACC_W-1:0]      acc_shift;
    logic [NT_W:0]         nt_inc;
    logic [VAL_W-1:0]      delta;
    logic [CNT_W-1:0]      rem_dec;
    logic [VIB_W-1:0]      vib_inc;
    logic [BIN_W-1:0]      bin_found;

    // Nonzero flags of the stored factors, and with the last word taken from the header.
    // The last factor word is the header word completed by the current byte.
    always_comb begin
        fac_last_word = {hdr_reg[HDR_W-BYTE_W-1:0], byte_in};
        for (int i = 0; i < FAC_DEPTH; i++) begin
            nz_cur[i] = (fac_reg[i] != '0);
        end
        nz_new = nz_cur;
        for (int k = 0; k < 8; k++) begin
            nz_new[24 + k] = (fac_last_word[21 - 3 * k +: FAC_W] != '0);
        end
    end

    // Datapath for one header byte or one nibble.
    always_comb begin
        offset_next = offset_reg;
        total_next  = total_reg;
        hdr_next    = hdr_reg;
        val_next    = val_reg;
        diff_next   = diff_reg;
        bin_next    = bin_reg;
        vib_next    = vib_reg;
        rem_next    = rem_reg;
        acc_next    = acc_reg;
        nt_next     = nt_reg;
        done_next   = done_reg;
        fac_we      = 1'b0;
        fac_word    = '0;
        res         = '0;
        cnt_raw     = {hdr_reg[6:0], byte_in};
        fac_sel     = fac_reg[bin_reg[FAC_IDX_W-1:0]];
        nib         = half_in ? byte_in[3:0] : byte_in[7:4];
        acc_shift   = {acc_reg[ACC_W-5:0], nib};
        nt_inc      = {1'b0, nt_reg} + 1'b1;
        delta       = sext_nibbles(acc_shift, fac_sel);
        rem_dec     = rem_reg - 1'b1;
        vib_inc     = vib_reg + 1'b1;
        bin_found   = next_bin(nz_cur, bin_reg + 1'b1);
        res.value   = val_reg;

        if (first_in) begin
            // A first byte restarts the segment.
            offset_next = OFF_W'(1);
            total_next  = '0;
            hdr_next    = '0;
            val_next    = '0;
            diff_next   = '0;
            bin_next    = '0;
            vib_next    = '0;
            rem_next    = '0;
            acc_next    = '0;
            nt_next     = '0;
            done_next   = 1'b0;
        end else if (!done_reg) begin
            if (offset_reg < DATA_START) begin
                offset_next = offset_reg + 1'b1;
                // Header word assembly.
                if (offset_reg == OFF_COUNT_HI) begin
                    hdr_next = {{(HDR_W-7){1'b0}}, byte_in[6:0]};
                end else if (offset_reg == OFF_COUNT_LO) begin
                    total_next = (cnt_raw == '0) ? CNT_W'(1) : cnt_raw;
                end else if (offset_reg > OFF_COUNT_LO) begin
                    case (offset_reg)
                        OFF_VALUE_HI, OFF_DIFF_HI, OFF_FAC0_HI, OFF_FAC1_HI, OFF_FAC2_HI,
                        OFF_FAC3_HI: hdr_next = {{(HDR_W-BYTE_W){1'b0}}, byte_in};
                        default:     hdr_next = {hdr_reg[HDR_W-BYTE_W-1:0], byte_in};
                    endcase
                end

                // Actions at the end of each header word.
                unique case (offset_reg)
                    OFF_VALUE_END: begin
                        val_next  = {{(VAL_W-HDR_W){1'b0}}, hdr_next};
                        res.emit  = 1'b1;
                        res.value = val_next;
                        res.last  = (total_reg == CNT_W'(1));
                        done_next = (total_reg == CNT_W'(1));
                    end
                    OFF_DIFF_END: begin
                        diff_next = {{(VAL_W-HDR_W){hdr_next[HDR_W-1]}}, hdr_next};
                        if (total_reg == CNT_W'(2)) begin
                            val_next  = val_reg + diff_next;
                            res.emit  = 1'b1;
                            res.value = val_next;
                            res.last  = 1'b1;
                            done_next = 1'b1;
                        end
                    end
                    OFF_FAC0_END: begin
                        fac_we   = 1'b1;
                        fac_word = FAC_WORD_W'(0);
                    end
                    OFF_FAC1_END: begin
                        fac_we   = 1'b1;
                        fac_word = FAC_WORD_W'(1);
                    end
                    OFF_FAC2_END: begin
                        fac_we   = 1'b1;
                        fac_word = FAC_WORD_W'(2);
                    end
                    OFF_FAC3_END: begin
                        fac_we    = 1'b1;
                        fac_word  = FAC_WORD_W'(3);
                        rem_next  = total_reg - CNT_W'(2);
                        val_next  = val_reg + diff_reg;
                        bin_next  = next_bin(nz_new, '0);
                        vib_next  = '0;
                        acc_next  = '0;
                        nt_next   = '0;
                        res.emit  = 1'b1;
                        res.value = val_next;
                        res.last  = (bin_next >= BIN_W'(NUM_BINS));
                        res.trunc = res.last;
                        done_next = res.last;
                    end
                    default: ;
                endcase
            end else begin
                // One nibble of packed second differences.
                if (nt_inc < {1'b0, fac_sel}) begin
                    acc_next = acc_shift;
                    nt_next  = nt_inc[NT_W-1:0];
                end else begin
                    diff_next = diff_reg + delta;
                    val_next  = val_reg + diff_reg + delta;
                    acc_next  = '0;
                    nt_next   = '0;
                    rem_next  = rem_dec;
                    vib_next  = vib_inc;
                    res.emit  = 1'b1;
                    res.value = val_next;
                    if (rem_dec == '0) begin
                        res.last  = 1'b1;
                        done_next = 1'b1;
                    end else if (vib_inc >= VIB_W'(BIN_SIZE)) begin
                        bin_next = bin_found;
                        vib_next = '0;
                        if (bin_found >= BIN_W'(NUM_BINS)) begin
                            res.last  = 1'b1;
                            res.trunc = 1'b1;
                            done_next = 1'b1;
                        end
                    end
                end
                res.more = !half_in && !done_next;
            end
        end
    end

    // Control and running state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            total_reg  <= '0;
            hdr_reg    <= '0;
            val_reg    <= '0;
            diff_reg   <= '0;
            bin_reg    <= '0;
            vib_reg    <= '0;
            rem_reg    <= '0;
            acc_reg    <= '0;
            nt_reg     <= '0;
            done_reg   <= 1'b1;
        end else if (step) begin
            offset_reg <= offset_next;
            total_reg  <= total_next;
            hdr_reg    <= hdr_next;
            val_reg    <= val_next;
            diff_reg   <= diff_next;
            bin_reg    <= bin_next;
            vib_reg    <= vib_next;
            rem_reg    <= rem_next;
            acc_reg    <= acc_next;
            nt_reg     <= nt_next;
            done_reg   <= done_next;
        end
    end

    // Packing factors, eight per header word, most significant first.
    always_ff @(posedge aclk) begin
        if (step && fac_we) begin
            for (int k = 0; k < 8; k++) begin
                fac_reg[{fac_word, 3'(k)}] <= hdr_next[21 - 3 * k +: FAC_W];
            end
        end
    end

endmodule

// File: src/binned_second_difference_decoder.sv
// Top level of the binned second-difference decoder: input holding stage and result register.
// Depends on bsdd_pkg and bsdd_core.
//
//  Channel | Ports            | Contents
//  --------+------------------+---------------------------------------------------
//  input   | s_t* (byte beat) | tdata[7:0] data_byte, tuser first_byte
//  result  | m_t* (sample)    | tdata[39:0] sample_value, tlast last_sample,
//          |                  | tuser truncated
//
// A header byte or a dropped byte takes one step; a data byte takes one step per nibble
// through the shared integrator, or one when its high nibble ends the segment. A data byte
// can yield up to two samples; each appears on m_t* the cycle after its step.
// A new beat is accepted in the same cycle the held one finishes.
// Reset (aresetn low, synchronous) leaves the decoder idle until a first_byte beat.
// When the result register is full and not taken, the held beat waits.
module binned_second_difference_decoder
    import bsdd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] data_byte
    input  logic              s_tuser,   // [0] first_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [VAL_W-1:0]  m_tdata,   // [39:0] sample_value
    output logic              m_tlast,
    output logic              m_tuser    // [0] truncated
);

    logic              hold_valid_reg;
    logic [BYTE_W-1:0] hold_byte_reg;
    logic              hold_first_reg;
    logic              half_reg;
    logic              out_valid_reg;
    logic [VAL_W-1:0]  out_value_reg;
    logic              out_last_reg;
    logic              out_trunc_reg;

    logic      out_ok;
    logic      advance;
    logic      consume;
    core_out_t core_res;

    // Step when a beat is held and the result register can take a sample.
    assign out_ok   = !out_valid_reg || m_tready;
    assign advance  = hold_valid_reg && out_ok;
    assign consume  = advance && !core_res.more;
    assign s_tready = !hold_valid_reg || consume;

    bsdd_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .byte_in  (hold_byte_reg),
        .first_in (hold_first_reg),
        .half_in  (half_reg),
        .res      (core_res)
    );

    // Input holding stage and nibble phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            half_reg       <= 1'b0;
        end else begin
            if (s_tready) begin
                hold_valid_reg <= s_tvalid;
            end
            if (advance) begin
                half_reg <= core_res.more;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            hold_byte_reg  <= s_tdata;
            hold_first_reg <= s_tuser;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ok) begin
            out_valid_reg <= advance && core_res.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && core_res.emit && out_ok) begin
            out_value_reg <= core_res.value;
            out_last_reg  <= core_res.last;
            out_trunc_reg <= core_res.trunc;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_trunc_reg;

    // The low-nibble phase only exists while its byte is still held.
    a_half_held: assert property (@(posedge aclk) disable iff (!aresetn)
        half_reg |-> hold_valid_reg)
        else $error("nibble phase set without a held beat");

    // A data byte that is not finished stays held for its low nibble.
    a_more_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && core_res.more) |=> (hold_valid_reg && half_reg))
        else $error("held beat lost before its low nibble");

    // A truncated sample always closes the segment.
    a_trunc_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_trunc_reg) |-> out_last_reg)
        else $error("truncated sample without last flag");

    // A new beat is taken over a held one only when the result side can move.
    a_take_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (hold_valid_reg && s_tready) |-> out_ok)
        else $error("held beat replaced while result register blocked");

endmodule
